// ----- rtl/m4qc_pkg.sv -----
// ----------------------------------------------------------------------------
// m4qc_pkg
// shared types and constants for the 4x4 quad combine transform
// ----------------------------------------------------------------------------
package m4qc_pkg;

    // default word format, signed fixed point
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // number of quads and of lanes
    localparam int NUM_QUADS = 4;
    localparam int NUM_LANES = 4;

    // configuration register file
    localparam int CFG_REGS       = 8;
    localparam int CFG_IDX_BITS   = 8;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_HALF_BITS  = 32;
    localparam int FIELD_BITS     = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_Q0_L01 = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q0_L23 = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q1_L01 = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q1_L23 = 8'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q2_L01 = 8'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q2_L23 = 8'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q3_L01 = 8'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Q3_L23 = 8'd7;

    // what one lane hands to the merging stage
    typedef struct packed {
        logic [FIELD_BITS-1:0] value;
        logic                  sat;
    } t_lane_res;

endpackage

// ----- rtl/mat4_quad_combine_transform.sv -----
// ----------------------------------------------------------------------------
// mat4_quad_combine_transform
// 4x4 fixed-point matrix times vector, one lane per result element
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------
//  vector   | in        | i_valid / o_ready         | i_vec_x, i_vec_y, i_vec_z, i_vec_w
//  result   | out       | o_valid / i_ready         | o_out_0..o_out_3, o_saturated
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  one vector transaction per clock while the output is not held; four register
//  stages (products, sum, round, merge) lie between acceptance and output.
//  the pipeline advances as one whole; it holds only while the output
//  register carries a result that the sink does not take
//  reset loads the identity matrix and empties the pipeline
//  config writes are always taken; writes to an index above seven are dropped
// ----------------------------------------------------------------------------
module mat4_quad_combine_transform #(
    parameter int WORD_BITS = m4qc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = m4qc_pkg::FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // vector input
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [m4qc_pkg::FIELD_BITS-1:0] i_vec_x,
    input  logic signed [m4qc_pkg::FIELD_BITS-1:0] i_vec_y,
    input  logic signed [m4qc_pkg::FIELD_BITS-1:0] i_vec_z,
    input  logic signed [m4qc_pkg::FIELD_BITS-1:0] i_vec_w,
    // result output
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [m4qc_pkg::FIELD_BITS-1:0] o_out_0,
    output logic signed [m4qc_pkg::FIELD_BITS-1:0] o_out_1,
    output logic signed [m4qc_pkg::FIELD_BITS-1:0] o_out_2,
    output logic signed [m4qc_pkg::FIELD_BITS-1:0] o_out_3,
    output logic                                 o_saturated,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [m4qc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [m4qc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import m4qc_pkg::*;

    // unit value in the chosen fixed-point format
    localparam logic [CFG_DATA_BITS-1:0] ONE_LO = CFG_DATA_BITS'(1) << FRAC_BITS;
    localparam logic [CFG_DATA_BITS-1:0] ONE_HI = ONE_LO << CFG_HALF_BITS;

    // saturation bounds as seen on the 32-bit outputs
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [FIELD_BITS-1:0] O_MAX = FIELD_BITS'(W_MAX);
    localparam logic [FIELD_BITS-1:0] O_MIN = FIELD_BITS'(W_MIN);

    localparam int PIPE_STAGES = 3;

    // matrix register file
    logic [CFG_DATA_BITS-1:0] r_cfg [CFG_REGS];

    // pipeline control
    logic                   w_en;
    logic [PIPE_STAGES-1:0] r_vld;
    logic                   w_in_acc;

    // lane wiring
    logic signed [WORD_BITS-1:0] w_vec  [NUM_QUADS];
    logic signed [WORD_BITS-1:0] w_coef [NUM_LANES][NUM_QUADS];
    t_lane_res                   w_res  [NUM_LANES];
    logic [FIELD_BITS-1:0]       w_out  [NUM_LANES];

    // ------------------------------------------------------------------
    // configuration: identity at reset, writes beyond the file ignored
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_REGS; k++) begin
                case (CFG_IDX_BITS'(k))
                    CFG_Q0_L01, CFG_Q2_L23: r_cfg[k] <= ONE_LO;  // elements 0 and 2
                    CFG_Q1_L01, CFG_Q3_L23: r_cfg[k] <= ONE_HI;  // elements 1 and 3
                    default:                r_cfg[k] <= '0;
                endcase
            end
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= CFG_Q3_L23)) begin
            r_cfg[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: the whole pipe moves unless the output is held
    // ------------------------------------------------------------------
    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en;
    assign w_in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_STAGES-2:0], w_in_acc};
        end
    end

    // ------------------------------------------------------------------
    // operand fan-out: vector weights and matrix elements per lane
    // ------------------------------------------------------------------
    assign w_vec[0] = i_vec_x[WORD_BITS-1:0];
    assign w_vec[1] = i_vec_y[WORD_BITS-1:0];
    assign w_vec[2] = i_vec_z[WORD_BITS-1:0];
    assign w_vec[3] = i_vec_w[WORD_BITS-1:0];

    // element e of quad q sits in register 2q + e/2, half e%2
    for (genvar e = 0; e < NUM_LANES; e++) begin : g_coef
        for (genvar q = 0; q < NUM_QUADS; q++) begin : g_quad
            localparam int REG  = 2 * q + e / 2;
            localparam int BASE = (e % 2) * CFG_HALF_BITS;
            assign w_coef[e][q] = r_cfg[REG][BASE +: WORD_BITS];
        end
    end

    // ------------------------------------------------------------------
    // lanes: one per result element
    // ------------------------------------------------------------------
    for (genvar e = 0; e < NUM_LANES; e++) begin : g_lane
        m4qc_lane #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_coef (w_coef[e]),
            .i_vec  (w_vec),
            .o_res  (w_res[e])
        );
    end

    // ------------------------------------------------------------------
    // merge: output register and combined clip flag
    // ------------------------------------------------------------------
    m4qc_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (r_vld[PIPE_STAGES-1]),
        .i_res       (w_res),
        .o_valid     (o_valid),
        .o_value     (w_out),
        .o_saturated (o_saturated)
    );

    assign o_out_0 = w_out[0];
    assign o_out_1 = w_out[1];
    assign o_out_2 = w_out[2];
    assign o_out_3 = w_out[3];

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // an accepted transaction enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_vld[0])
        else $error("accepted vector did not enter the pipeline");

    // a held output freezes the stage valids
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline moved while output was held");

    // a new result only comes from the last lane stage
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_vld[PIPE_STAGES-1]))
        else $error("output valid without a result in the last stage");

    // a clip flag means at least one element sits on a bound
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_out_0 == O_MAX || o_out_0 == O_MIN ||
             o_out_1 == O_MAX || o_out_1 == O_MIN ||
             o_out_2 == O_MAX || o_out_2 == O_MIN ||
             o_out_3 == O_MAX || o_out_3 == O_MIN))
        else $error("clip flag set with no element at a bound");

endmodule

// ----- rtl/m4qc_lane.sv -----
// ----------------------------------------------------------------------------
// m4qc_lane
// one result element: four products, wide sum, round, shift and saturate
// ----------------------------------------------------------------------------
module m4qc_lane #(
    parameter int WORD_BITS = m4qc_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = m4qc_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_coef [m4qc_pkg::NUM_QUADS],
    input  logic signed [WORD_BITS-1:0] i_vec  [m4qc_pkg::NUM_QUADS],
    output m4qc_pkg::t_lane_res         o_res
);
    import m4qc_pkg::*;

    localparam int PW     = 2 * WORD_BITS;
    localparam int SW     = PW + 2;
    localparam int RND_SH = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam logic signed [SW-1:0] RND = (FRAC_BITS > 0) ? (SW'(1) << RND_SH) : '0;
    localparam logic signed [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    logic signed [PW-1:0] r_prod [NUM_QUADS];
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] n_sum;
    logic signed [SW-1:0] n_rnd;
    logic signed [SW-1:0] n_shf;
    logic [SW-WORD_BITS:0] w_top;
    logic                  w_fits;
    logic signed [WORD_BITS-1:0] n_word;
    t_lane_res             r_res;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int q = 0; q < NUM_QUADS; q++) begin
                r_prod[q] <= i_coef[q] * i_vec[q];
            end
        end
    end

    // stage 2: exact sum
    always_comb begin
        n_sum = '0;
        for (int q = 0; q < NUM_QUADS; q++) begin
            n_sum = n_sum + SW'(r_prod[q]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    // stage 3: round half up, drop fraction, clip
    always_comb begin
        n_rnd  = r_sum + RND;
        n_shf  = n_rnd >>> FRAC_BITS;
        w_top  = n_shf[SW-1:WORD_BITS-1];
        w_fits = (&w_top) || (~|w_top);
        if (w_fits) begin
            n_word = n_shf[WORD_BITS-1:0];
        end else if (n_shf[SW-1]) begin
            n_word = W_MIN;
        end else begin
            n_word = W_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.value <= FIELD_BITS'(n_word);
            r_res.sat   <= ~w_fits;
        end
    end

    assign o_res = r_res;

endmodule

// ----- rtl/m4qc_merge.sv -----
// ----------------------------------------------------------------------------
// m4qc_merge
// gathers the lane results into one output transaction
// ----------------------------------------------------------------------------
module m4qc_merge (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  m4qc_pkg::t_lane_res     i_res [m4qc_pkg::NUM_LANES],
    output logic                    o_valid,
    output logic [m4qc_pkg::FIELD_BITS-1:0] o_value [m4qc_pkg::NUM_LANES],
    output logic                    o_saturated
);
    import m4qc_pkg::*;

    logic                  r_valid;
    logic [FIELD_BITS-1:0] r_value [NUM_LANES];
    logic                  r_sat;
    logic                  n_sat;

    // any clipped lane flags the whole vector
    always_comb begin
        n_sat = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_sat = n_sat | i_res[l].sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                r_value[l] <= i_res[l].value;
            end
            r_sat <= n_sat;
        end
    end

    assign o_valid     = r_valid;
    assign o_value     = r_value;
    assign o_saturated = r_sat;

endmodule
